### rtl/pmpf_pkg.sv
// Shared constants, types and helpers for the payload multi-pattern filter.
`timescale 1ns / 1ps
`default_nettype none

package pmpf_pkg;

    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 8;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 4;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PAT_W    = MAX_PATTERN_LEN * BYTE_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KINDS     = 3'd5;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef byte_t [MAX_PATTERN_LEN-1:0] pat_t;

    // pattern set seen by every cell of the window chain
    typedef struct packed {
        pat_t [NUM_PATTERNS-1:0] pats;
        len_t [NUM_PATTERNS-1:0] lens;
    } cell_cfg_t;

    // length nibble above the window size counts as the full size
    function automatic len_t sat_len(input logic [LEN_W-1:0] nib);
        if (nib > LEN_W'(MAX_PATTERN_LEN))
            return LEN_W'(MAX_PATTERN_LEN);
        else
            return nib;
    endfunction

endpackage

`default_nettype wire

### rtl/payload_multi_pattern_filter.sv
// Top level of the payload multi-pattern filter: config, cell chain, verdict.
// The verdict of a packet is registered into the output register, or into the skid
//   entry while the output register is held, when its last item is accepted.
// Throughput: one item per cycle while in_stall is low; all window lanes are compared
//   in parallel by the chain of byte cells, so each unstalled cycle takes a new byte.
// A two-entry output stage (register plus skid) keeps input flowing while a verdict waits.
// Reset: configuration, window presence, found flags and output/skid valid flags clear.
`timescale 1ns / 1ps
`default_nettype none

module payload_multi_pattern_filter (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write,
    input  wire  [pmpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [pmpf_pkg::CFG_W-1:0]         cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [7:0]                         data_byte,
    input  wire                                byte_valid,
    input  wire                                packet_end,
    input  wire                                no_payload,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic                               accept
);
    import pmpf_pkg::*;

    cell_cfg_t                cfg_reg;
    logic [NUM_PATTERNS-1:0]  kind_reg;
    logic [NUM_PATTERNS-1:0]  found_reg;
    logic [NUM_PATTERNS-1:0]  found_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     accept_reg;
    logic                     accept_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    logic                     skid_accept_reg;
    logic                     skid_accept_next;

    logic in_acc;
    logic shift;
    logic clear;
    logic out_pop;
    logic verdict;
    logic [NUM_PATTERNS-1:0] match;

    byte_t [MAX_PATTERN_LEN:0]    chain_byte;
    logic  [MAX_PATTERN_LEN:0]    chain_present;
    logic  [NUM_PATTERNS-1:0]     cell_hit [MAX_PATTERN_LEN];

    assign in_acc  = in_valid && !in_stall;
    assign shift   = in_acc && byte_valid;
    assign clear   = in_acc && packet_end;
    assign out_pop = out_valid_reg && !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            kind_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                [CFG_PATTERN_0:CFG_PATTERN_3]:
                begin
                    for (int p = 0; p < NUM_PATTERNS; p++)
                    begin
                        if (cfg_index == CFG_IDX_W'(p))
                            cfg_reg.pats[p] <= cfg_data[PAT_W-1:0];
                    end
                end
                CFG_LENGTHS:
                begin
                    for (int p = 0; p < NUM_PATTERNS; p++)
                        cfg_reg.lens[p] <= sat_len(cfg_data[p*LEN_W +: LEN_W]);
                end
                CFG_KINDS:
                    kind_reg <= cfg_data[NUM_PATTERNS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // byte cell chain: lane 0 is the incoming byte
    assign chain_byte[0]    = data_byte;
    assign chain_present[0] = byte_valid;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
    begin : g_cell
        pmpf_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift       (shift),
            .clear       (clear),
            .lane        (LEN_W'(k)),
            .cfg         (cfg_reg),
            .byte_in     (chain_byte[k]),
            .present_in  (chain_present[k]),
            .byte_out    (chain_byte[k+1]),
            .present_out (chain_present[k+1]),
            .hit         (cell_hit[k])
        );
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            match[p] = byte_valid && (cfg_reg.lens[p] != '0);
            for (int k = 0; k < MAX_PATTERN_LEN; k++)
                match[p] = match[p] && cell_hit[k][p];
        end
    end

    always_comb
    begin
        logic [NUM_PATTERNS-1:0] seen;
        seen    = found_reg | match;
        verdict = !no_payload;
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            if (cfg_reg.lens[p] != '0)
            begin
                if (kind_reg[p] ? seen[p] : !seen[p])
                    verdict = 1'b0;
            end
        end
        found_next = found_reg;
        if (in_acc)
            found_next = clear ? '0 : seen;
    end

    // output register with one skid entry
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        accept_next      = accept_reg;
        skid_valid_next  = skid_valid_reg;
        skid_accept_next = skid_accept_reg;
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                accept_next     = skid_accept_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (clear)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_next = 1'b1;
                accept_next    = verdict;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_accept_next = verdict;
            end
        end
        else if (out_pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accept_reg      <= accept_next;
        skid_accept_reg <= skid_accept_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign accept    = accept_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_found_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && packet_end) |=> (found_reg == '0))
        else $error("found flags not cleared after verdict");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !packet_end)
        |=> ((found_reg & $past(found_reg)) == $past(found_reg)))
        else $error("found flag lost within a packet");

    a_verdict_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && packet_end) |=> out_valid_reg)
        else $error("verdict request did not reach output");

endmodule

`default_nettype wire

### rtl/pmpf_cell.sv
// One byte lane of the sliding window: holds a byte for the next lane and compares its input byte to all patterns.
`timescale 1ns / 1ps
`default_nettype none

module pmpf_cell (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               shift,
    input  wire                               clear,
    input  wire  [pmpf_pkg::LEN_W-1:0]        lane,
    input  wire  pmpf_pkg::cell_cfg_t         cfg,
    input  wire  [pmpf_pkg::BYTE_W-1:0]       byte_in,
    input  wire                               present_in,
    output logic [pmpf_pkg::BYTE_W-1:0]       byte_out,
    output logic                              present_out,
    output logic [pmpf_pkg::NUM_PATTERNS-1:0] hit
);
    import pmpf_pkg::*;

    byte_t byte_reg;
    logic  present_reg;
    logic  present_next;

    // lane k of the window is checked against pattern byte (len-1-k)
    always_comb
    begin
        len_t  idx;
        byte_t sel;
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            idx = cfg.lens[p] - LEN_W'(1) - lane;
            sel = '0;
            for (int j = 0; j < MAX_PATTERN_LEN; j++)
            begin
                if (idx == LEN_W'(j))
                    sel = cfg.pats[p][j];
            end
            hit[p] = (lane >= cfg.lens[p]) || (present_in && (byte_in == sel));
        end
    end

    always_comb
    begin
        present_next = present_reg;
        if (shift)
            present_next = present_in;
        if (clear)
            present_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            present_reg <= 1'b0;
        else
            present_reg <= present_next;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            byte_reg <= byte_in;
    end

    assign byte_out    = byte_reg;
    assign present_out = present_reg;

endmodule

`default_nettype wire

### verif/tb_payload_multi_pattern_filter.sv
// Self-checking testbench for the payload multi-pattern filter.
`timescale 1ns / 1ps

module tb_payload_multi_pattern_filter;

    import pmpf_pkg::*;

    // indexes past the register list, written only to show they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS  = 1820;
    localparam int PHASE_ITEMS   = 160;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TIMEOUT_NS    = 20_000_000;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte  = '0;
    logic                 byte_valid = 1'b0;
    logic                 packet_end = 1'b0;
    logic                 no_payload = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 accept;

    // predictor state and its copy of the registers
    logic [55:0]      win_hist   = '0;
    logic [2:0]       seen_cnt   = '0;
    logic [3:0]       found_bits = '0;
    logic [CFG_W-1:0] pat_cfg [NUM_PATTERNS];
    logic [15:0]      len_cfg    = '0;
    logic [3:0]       kind_cfg   = '0;

    logic verdicts_due [$];
    logic want_accept;
    int   errors     = 0;
    int   items_sent = 0;
    bit   in_gaps    = 1'b1;
    bit   out_stalls = 1'b1;
    bit   hold_req   = 1'b0;

    payload_multi_pattern_filter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .packet_end (packet_end),
        .no_payload (no_payload),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accept     (accept)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // effective length of pattern p, nibbles above the window size clamp
    function automatic int pattern_span(input int p);
        int nib;
        nib = int'(len_cfg[4*p +: 4]);
        return (nib > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : nib;
    endfunction

    // advances the filter state by one request; returns 1 when a verdict is due
    function automatic bit filter_byte_step(input logic [7:0] b, input logic bv,
                                            input logic last, input logic nopay,
                                            output logic verdict);
        logic [63:0] seq;
        int          span;
        bit          hit;
        verdict = 1'b0;
        if (bv)
        begin
            seq = {win_hist, b};
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                span = pattern_span(p);
                if (span == 0 || int'(seen_cnt) + 1 < span)
                    continue;
                // pattern byte 0 lines up with the oldest byte of the span
                hit = 1'b1;
                for (int i = 0; i < span; i++)
                    if (pat_cfg[p][8*i +: 8] != seq[8*(span-1-i) +: 8])
                        hit = 1'b0;
                if (hit)
                    found_bits[p] = 1'b1;
            end
            win_hist = seq[55:0];
            if (seen_cnt < 3'(MAX_PATTERN_LEN - 1))
                seen_cnt = seen_cnt + 3'd1;
        end
        if (!last)
            return 1'b0;
        verdict = !nopay;
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            if (pattern_span(p) == 0)
                continue;
            if (kind_cfg[p] ? found_bits[p] : !found_bits[p])
                verdict = 1'b0;
        end
        win_hist   = '0;
        seen_cnt   = '0;
        found_bits = '0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // payload filler, half of it drawn from the configured pattern bytes
    function automatic logic [7:0] filler_byte();
        int p;
        int lane;
        p    = $urandom_range(0, NUM_PATTERNS - 1);
        lane = $urandom_range(0, MAX_PATTERN_LEN - 1);
        if ($urandom_range(0, 1) == 0)
            return pat_cfg[p][8*lane +: 8];
        return 8'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx <= CFG_PATTERN_3)
            pat_cfg[idx[1:0]] = value;
        else if (idx == CFG_LENGTHS)
            len_cfg = value[15:0];
        else if (idx == CFG_KINDS)
            kind_cfg = value[3:0];
        @(posedge clk);
    endtask

    task automatic send_item(input logic [7:0] b, input logic bv, input logic last,
                             input logic nopay);
        logic verdict;
        int   gap;
        in_valid   <= 1'b1;
        data_byte  <= b;
        byte_valid <= bv;
        packet_end <= last;
        no_payload <= nopay;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (filter_byte_step(b, bv, last, nopay, verdict))
            verdicts_due.insert(verdicts_due.size(), verdict);
        items_sent++;
        gap = in_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender stops until every verdict is back, then lets the block settle
    task automatic wait_for_verdicts();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (verdicts_due.size() != 0)
        begin
            $error("accept: %0d expected verdicts never arrived", verdicts_due.size());
            errors++;
            verdicts_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_packet();
        logic [7:0] body [$];
        int         nbytes;
        int         r;
        int         p;
        int         span;
        int         cut;
        int         at;
        bit         split_end;
        logic       last;
        logic       nopay;
        r = $urandom_range(0, 99);
        if (r < 10)
            nbytes = 0;
        else if (r < 70)
            nbytes = $urandom_range(1, 8);
        else if (r < 95)
            nbytes = $urandom_range(9, 24);
        else
            nbytes = $urandom_range(25, 60);
        for (int i = 0; i < nbytes; i++)
            body.insert(body.size(), filler_byte());
        // plant a whole pattern, or one cut short by a byte for a near miss
        p    = $urandom_range(0, NUM_PATTERNS - 1);
        span = pattern_span(p);
        if (span > 0 && $urandom_range(0, 99) < 65)
        begin
            cut = (span > 1 && $urandom_range(0, 99) < 15) ? 1 : 0;
            at  = $urandom_range(0, nbytes);
            for (int i = span - 1 - cut; i >= 0; i--)
                body.insert(at, pat_cfg[p][8*i +: 8]);
        end
        split_end = (body.size() == 0) || ($urandom_range(0, 99) < 30);
        for (int i = 0; i < body.size(); i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_item(8'($urandom), 1'b0, 1'b0, 1'($urandom));
            last  = !split_end && (i == body.size() - 1);
            nopay = last ? ($urandom_range(0, 99) < 8) : ($urandom_range(0, 99) < 5);
            send_item(body[i], 1'b1, last, nopay);
        end
        if (split_end)
            send_item(8'($urandom), 1'b0, 1'b1, $urandom_range(0, 99) < 8);
    endtask

    task automatic load_random_setup(input int mode);
        logic [7:0]       alpha [4];
        logic [CFG_W-1:0] pat;
        logic [15:0]      lens;
        logic [3:0]       kinds;
        int               r;
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
        alpha[2] = 8'($urandom);
        alpha[3] = 8'($urandom);
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                pat = '0;
            else if (r < 25)
                pat = '1;
            else if (r < 70)
                for (int i = 0; i < MAX_PATTERN_LEN; i++)
                    pat[8*i +: 8] = alpha[$urandom_range(0, 3)];
            else
                pat = {$urandom, $urandom};
            write_reg(CFG_PATTERN_0 + CFG_IDX_W'(p), pat);
        end
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                lens[4*p +: 4] = 4'd0;
            else if (r < 25)
                lens[4*p +: 4] = 4'($urandom_range(9, 15));
            else
                lens[4*p +: 4] = 4'($urandom_range(1, 8));
        end
        kinds = 4'($urandom);
        case (mode)
            0: lens = '0;
            1:
            begin
                lens  = '1;
                kinds = '1;
            end
            2:
            begin
                lens  = 16'h8888;
                kinds = '0;
            end
            3:
            begin
                lens  = 16'h1111;
                kinds = 4'hA;
            end
            default: ;
        endcase
        write_reg(CFG_LENGTHS, CFG_W'(lens));
        write_reg(CFG_KINDS, CFG_W'(kinds));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
    endtask

    // reset values, each special case, field extremes
    task automatic test_directed_cases();
        // nothing enabled after reset: only no_payload rejects
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1, 1'b1);
        wait_for_verdicts();

        // "AB" and eight 0xFF must be present; eight zeros (nibble 0xF) and 0x7E must not
        write_reg(CFG_PATTERN_0, 64'h4241);
        write_reg(CFG_PATTERN_0 + CFG_IDX_W'(1), '1);
        write_reg(CFG_PATTERN_0 + CFG_IDX_W'(2), '0);
        write_reg(CFG_PATTERN_3, 64'h7E);
        write_reg(CFG_LENGTHS, 64'h1F82);
        write_reg(CFG_KINDS, 64'hC);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);

        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            // empty request with no_payload mid-packet must not disturb the window
            if (i == 4)
                send_item(8'h7E, 1'b0, 1'b0, 1'b1);
            send_item(8'hFF, 1'b1, i == 7, 1'b0);
        end
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        wait_for_verdicts();

        write_reg(CFG_LENGTHS, 64'h0002);
        write_reg(CFG_KINDS, 64'h0);
        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b1, 1'b1);
        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b1, 1'b0);
        wait_for_verdicts();
    endtask

    // output held off long enough that the block backs up into its input
    task automatic test_backpressure();
        write_reg(CFG_PATTERN_0, 64'h41);
        write_reg(CFG_LENGTHS, 64'h0001);
        write_reg(CFG_KINDS, 64'h0);
        in_gaps  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item($urandom_range(0, 1) ? 8'h41 : 8'h42, 1'b1, 1'b1, 1'b0);
        wait_for_verdicts();
        in_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int base;
        int start;
        int phase;
        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            wait_for_verdicts();
            load_random_setup(phase);
            in_gaps    = (phase % 3) != 1;
            out_stalls = (phase % 4) != 2;
            start      = items_sent;
            while (items_sent - start < PHASE_ITEMS && items_sent - base < RANDOM_ITEMS)
            begin
                send_random_packet();
                if ($urandom_range(0, 99) < 3)
                    wait_for_verdicts();
            end
            phase++;
        end
        wait_for_verdicts();
    endtask

    // receiver: random stall runs, plus the long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (out_stalls && $urandom_range(0, 99) < 30)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("accept: verdict %0b with none expected", accept);
                errors++;
            end
            else
            begin
                want_accept = verdicts_due.pop_front();
                if (accept !== want_accept)
                begin
                    $error("accept mismatch: expected %0b, actual %0b", want_accept, accept);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
            pat_cfg[p] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_backpressure();
        test_random_traffic();
        wait_for_verdicts();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/pmpf_pkg.sv
rtl/pmpf_cell.sv
rtl/payload_multi_pattern_filter.sv
verif/tb_payload_multi_pattern_filter.sv
